[design/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OpW  = 32;
    localparam int MagW = 64;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_INV = 3'd4;
    localparam logic [2:0] MODE_NEG = 3'd5;
    localparam logic [2:0] MODE_RED = 3'd6;
    localparam logic [2:0] MODE_BAD = 3'd7;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic mul_d;
        logic form;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } rau_cmd_t;

    typedef struct packed {
        logic err;
        logic gcd_done;
        logic div_done;
    } rau_sts_t;

endpackage

[design/rau_datapath.sv]
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, one 32x32 multiplier, binary GCD and a shared
// restoring divider that divides both raw terms by the GCD in parallel.
// ----------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
(
    input  logic                 aclk,
    input  logic [2:0]           mode,
    input  logic signed [31:0]   a_num,
    input  logic signed [31:0]   a_den,
    input  logic signed [31:0]   b_num,
    input  logic signed [31:0]   b_den,
    input  rau_cmd_t             cmd,
    output rau_sts_t             sts,
    output logic [63:0]          result_num,
    output logic [62:0]          result_den,
    output logic                 less_than,
    output logic                 equal
);

    logic [2:0]  mode_reg;
    logic        an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [31:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic        eq_reg;
    logic [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic        s0_reg, s1_reg, s2_reg, s3_reg;
    logic [63:0] nm_reg, dm_reg;
    logic        ns_reg, ds_reg, err_reg;
    logic [63:0] u_reg, v_reg;
    logic [5:0]  com_reg;
    logic        gdone_reg;
    logic [63:0] qn_reg, qd_reg, rn_reg, rd_reg;
    logic [6:0]  cnt_reg;
    logic        lt_reg;

    logic [31:0] mx, my;
    logic [63:0] prod;
    logic [64:0] sum_m;
    logic [63:0] nmag, dmag;
    logic        nneg, dneg;
    logic [64:0] rn_t, rd_t;
    logic [63:0] rnum_v;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // p0 = a_num*b_den, p1 = a_den*b_den, p2 = a_den*b_num, p3 = a_num*b_num
    always_comb begin
        mx = an_m_reg;
        my = bd_m_reg;
        if (cmd.mul_b) begin
            mx = ad_m_reg; my = bd_m_reg;
        end else if (cmd.mul_c) begin
            mx = ad_m_reg; my = bn_m_reg;
        end else if (cmd.mul_d) begin
            mx = an_m_reg; my = bn_m_reg;
        end
        prod = {32'd0, mx} * {32'd0, my};
    end

    always_comb begin
        logic sb;
        sb = (mode_reg == MODE_SUB) ? (~s2_reg & (p2_reg != 64'd0)) : s2_reg;
        nneg = 1'b0; nmag = 64'd0; dneg = 1'b0; dmag = 64'd0; sum_m = 65'd0;
        case (mode_reg)
            MODE_ADD, MODE_SUB: begin
                if (s0_reg == sb) begin
                    sum_m = {1'b0, p0_reg} + {1'b0, p2_reg};
                    nneg = s0_reg;
                end else if (p0_reg >= p2_reg) begin
                    sum_m = {1'b0, p0_reg - p2_reg};
                    nneg = s0_reg;
                end else begin
                    sum_m = {1'b0, p2_reg - p0_reg};
                    nneg = sb;
                end
                nmag = sum_m[63:0];
                dmag = p1_reg; dneg = s1_reg;
            end
            MODE_MUL: begin
                nmag = p3_reg; nneg = s3_reg; dmag = p1_reg; dneg = s1_reg;
            end
            MODE_DIV: begin
                nmag = p0_reg; nneg = s0_reg; dmag = p2_reg; dneg = s2_reg;
            end
            MODE_INV: begin
                nmag = {32'd0, ad_m_reg}; nneg = ad_s_reg;
                dmag = {32'd0, an_m_reg}; dneg = an_s_reg;
            end
            MODE_NEG: begin
                nmag = {32'd0, an_m_reg}; nneg = ~an_s_reg;
                dmag = {32'd0, ad_m_reg}; dneg = ad_s_reg;
            end
            default: begin
                nmag = {32'd0, an_m_reg}; nneg = an_s_reg;
                dmag = {32'd0, ad_m_reg}; dneg = ad_s_reg;
            end
        endcase
        if (nmag == 64'd0) nneg = 1'b0;
    end

    assign rn_t = {rn_reg, qn_reg[63]} - {1'b0, u_reg};
    assign rd_t = {rd_reg, qd_reg[63]} - {1'b0, u_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode;
            an_s_reg <= a_num[31]; an_m_reg <= mag32(a_num);
            ad_s_reg <= a_den[31]; ad_m_reg <= mag32(a_den);
            bn_s_reg <= b_num[31]; bn_m_reg <= mag32(b_num);
            bd_s_reg <= b_den[31]; bd_m_reg <= mag32(b_den);
            eq_reg   <= (a_num == b_num) && (a_den == b_den);
        end
        if (cmd.mul_a) begin
            p0_reg <= prod;
            s0_reg <= (an_s_reg ^ bd_s_reg) && (prod != 64'd0);
        end
        if (cmd.mul_b) begin
            p1_reg <= prod;
            s1_reg <= (ad_s_reg ^ bd_s_reg) && (prod != 64'd0);
        end
        if (cmd.mul_c) begin
            p2_reg <= prod;
            s2_reg <= (ad_s_reg ^ bn_s_reg) && (prod != 64'd0);
        end
        if (cmd.mul_d) begin
            p3_reg <= prod;
            s3_reg <= (an_s_reg ^ bn_s_reg) && (prod != 64'd0);
        end
        if (cmd.form) begin
            lt_reg  <= ((s0_reg ? -$signed(p0_reg) : $signed(p0_reg))
                      < (s2_reg ? -$signed(p2_reg) : $signed(p2_reg)));
            nm_reg  <= nmag; ns_reg <= nneg;
            dm_reg  <= dmag; ds_reg <= dneg;
            err_reg <= (mode_reg == MODE_BAD) || (dmag == 64'd0);
        end
        if (cmd.gcd_init) begin
            u_reg <= nm_reg; v_reg <= dm_reg; com_reg <= 6'd0; gdone_reg <= 1'b0;
            if (nm_reg == 64'd0) begin
                u_reg <= dm_reg; gdone_reg <= 1'b1;
            end
        end else if (cmd.gcd_step && !gdone_reg) begin
            if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1; v_reg <= v_reg >> 1; com_reg <= com_reg + 6'd1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_reg > v_reg) begin
                u_reg <= v_reg; v_reg <= u_reg - v_reg;
            end else if (u_reg == v_reg) begin
                u_reg <= u_reg << com_reg; gdone_reg <= 1'b1;
            end else begin
                v_reg <= v_reg - u_reg;
            end
        end
        if (cmd.div_init) begin
            qn_reg <= nm_reg; qd_reg <= dm_reg;
            rn_reg <= 64'd0; rd_reg <= 64'd0; cnt_reg <= 7'd0;
        end else if (cmd.div_step) begin
            if (!rn_t[64]) begin
                rn_reg <= rn_t[63:0]; qn_reg <= {qn_reg[62:0], 1'b1};
            end else begin
                rn_reg <= {rn_reg[62:0], qn_reg[63]}; qn_reg <= {qn_reg[62:0], 1'b0};
            end
            if (!rd_t[64]) begin
                rd_reg <= rd_t[63:0]; qd_reg <= {qd_reg[62:0], 1'b1};
            end else begin
                rd_reg <= {rd_reg[62:0], qd_reg[63]}; qd_reg <= {qd_reg[62:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_comb begin
        if ((ns_reg != ds_reg) && (qn_reg != 64'd0))
            rnum_v = 64'd0 - qn_reg;
        else
            rnum_v = qn_reg[63] ? 64'h7fff_ffff_ffff_ffff : qn_reg;
    end

    assign result_num = err_reg ? 64'd0 : rnum_v;
    assign result_den = err_reg ? 63'd1 : qd_reg[62:0];
    assign less_than  = lt_reg;
    assign equal      = eq_reg;
    assign sts.err      = err_reg;
    assign sts.gcd_done = gdone_reg;
    assign sts.div_done = (cnt_reg == 7'd64);

endmodule

[design/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply, form, GCD, divide, then present one result; error items skip GCD and divide.
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  rau_sts_t sts,
    output rau_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MULA = 4'd1;
    localparam logic [3:0] ST_MULB = 4'd2;
    localparam logic [3:0] ST_MULC = 4'd3;
    localparam logic [3:0] ST_MULD = 4'd4;
    localparam logic [3:0] ST_FORM = 4'd5;
    localparam logic [3:0] ST_GINI = 4'd6;
    localparam logic [3:0] ST_GCD  = 4'd7;
    localparam logic [3:0] ST_DINI = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1; state_next = ST_MULA;
                end
            end
            ST_MULA: begin cmd.mul_a = 1'b1; state_next = ST_MULB; end
            ST_MULB: begin cmd.mul_b = 1'b1; state_next = ST_MULC; end
            ST_MULC: begin cmd.mul_c = 1'b1; state_next = ST_MULD; end
            ST_MULD: begin cmd.mul_d = 1'b1; state_next = ST_FORM; end
            ST_FORM: begin cmd.form = 1'b1; state_next = ST_GINI; end
            ST_GINI: begin
                if (sts.err) state_next = ST_OUT;
                else begin cmd.gcd_init = 1'b1; state_next = ST_GCD; end
            end
            ST_GCD: begin
                cmd.gcd_step = 1'b1;
                if (sts.gcd_done) state_next = ST_DINI;
            end
            ST_DINI: begin cmd.div_init = 1'b1; state_next = ST_DIV; end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_OUT;
                else cmd.div_step = 1'b1;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

endmodule

[design/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational add/sub/mul/div/inverse/negate/reduce with binary GCD reduction.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low first)                      | tuser
// s_      | in  | a_num, a_den, b_num, b_den (128 bits)  | mode (3)
// m_      | out | result_num, result_den (128 bits)      | less_than, equal, error
// One item at a time: after the input transfer, the four multiply states, the
// form state and the GCD setup state, then binary GCD steps (shift or subtract),
// then the divide setup and the divide steps that divide numerator and
// denominator by the GCD together. Hold the result until m_tready.
// Error items skip the GCD and divide. aresetn returns to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den
    input  logic [2:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_num, result_den, zero pad
    output logic [2:0]   m_tuser    // less_than, equal, error
);

    rau_cmd_t    cmd;
    rau_sts_t    sts;
    logic [63:0] rnum;
    logic [62:0] rden;
    logic        lt, eq;

    rau_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    rau_datapath u_dp (
        .aclk(aclk), .mode(s_tuser),
        .a_num(s_tdata[31:0]), .a_den(s_tdata[63:32]),
        .b_num(s_tdata[95:64]), .b_den(s_tdata[127:96]),
        .cmd(cmd), .sts(sts),
        .result_num(rnum), .result_den(rden),
        .less_than(lt), .equal(eq)
    );

    assign m_tdata = {1'b0, rden, rnum};
    assign m_tuser = {sts.err, eq, lt};

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_err_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata[127:64] == 64'd1)
        else $error("error result must be 0/1");
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[126:64] != 63'd0) else $error("zero denominator out");

endmodule
